>>> hdl/assert_macros.svh
// Assertion macros shared by the bitmap unpacker RTL.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

>>> hdl/bpup_pkg.sv
// Types and codes for the bitmap pixel unpacker.
// No dependencies; used by bpup_seq, bpup_lookup, the top level and the testbench.
package bpup_pkg;

  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_PIXEL   = 1'b1;

  localparam logic [2:0] DEPTH_1  = 3'd0;
  localparam logic [2:0] DEPTH_2  = 3'd1;
  localparam logic [2:0] DEPTH_4  = 3'd2;
  localparam logic [2:0] DEPTH_8  = 3'd3;
  localparam logic [2:0] DEPTH_24 = 3'd4;

  localparam int REG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [REG_IDX_W-1:0] REG_DEPTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [12:0] HEIGHT_LIMIT = 13'd4096;

  typedef struct packed {
    logic [2:0]  depth_code;
    logic [12:0] width;
    logic [12:0] height;
  } bpup_cfg_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  index;
    logic [31:0] color;
  } bpup_pal_wr_t;

  // one pixel request toward the palette lookup
  typedef struct packed {
    logic        direct;
    logic [7:0]  index;
    logic [23:0] rgb;
    logic        eor;
    logic        eoi;
  } bpup_pix_t;

endpackage

>>> hdl/bpup_in_if.sv
// Input channel: palette writes and pixel data bytes.
// Valid/ready handshake; no dependencies.
interface bpup_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  data_byte;
  logic [7:0]  palette_index;
  logic [31:0] palette_color;

  modport source(output valid, command, data_byte, palette_index, palette_color,
                 input ready);
  modport sink(input valid, command, data_byte, palette_index, palette_color,
               output ready);
endinterface

>>> hdl/bpup_out_if.sv
// Output channel: decoded pixels with row and image flags.
// Valid/ready handshake; no dependencies.
interface bpup_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha_byte;
  logic       end_of_row;
  logic       end_of_image;

  modport source(output valid, red, green, blue, alpha_byte, end_of_row, end_of_image,
                 input ready);
  modport sink(input valid, red, green, blue, alpha_byte, end_of_row, end_of_image,
               output ready);
endinterface

>>> hdl/bpup_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module bpup_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/bpup_seq.sv
// Row/column bookkeeping and byte unpacker: one pixel request per cycle while iss_ready holds.
// Depends on bpup_pkg, bpup_in_if, assert_macros.svh.
`include "assert_macros.svh"
module bpup_seq #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bpup_pkg::bpup_cfg_t  cfg,
  bpup_in_if.sink              pix_in,
  output bpup_pkg::bpup_pal_wr_t pal_wr,
  output logic                 iss_valid,
  output bpup_pkg::bpup_pix_t  iss,
  input  logic                 iss_ready
);
  import bpup_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (CW > 13) ? CW : 13;
  localparam int RBW = $clog2(3 * MAX_WIDTH + 4);
  localparam int RCW = RBW + 2;

  logic [CW-1:0]  col, col_next;
  logic [RBW-1:0] rbc, rbc_next;
  logic [11:0]    row, row_next;
  logic [7:0]     hold_b, hold_b_next, hold_g, hold_g_next;
  logic [1:0]     phase, phase_next;

  logic        u_valid;
  logic [3:0]  u_count;
  logic [7:0]  u_byte;
  logic [1:0]  u_code;
  logic        u_eor, u_eoi, u_direct;
  logic [23:0] u_rgb;
  logic [7:0]  u_index;

  logic        u_load, ld_eor, ld_eoi, ld_direct;
  logic [3:0]  ld_count;
  logic [23:0] ld_rgb;

  logic            issue, load_ok, acc, pix_acc;
  logic [CW-1:0]   w_eff, avail;
  logic [12:0]     h_eff;
  logic [RCW-1:0]  wr, rb_wide;
  logic [RBW-1:0]  row_bytes, rbc_inc;
  logic [3:0]      per_byte, n;
  logic            last, row_last, col_lt_w;

  assign issue   = u_valid && iss_ready;
  assign load_ok = !u_valid || (issue && u_count == 4'd1);
  assign acc     = pix_in.valid && load_ok;
  assign pix_acc = acc && pix_in.command == CMD_PIXEL && cfg.depth_code <= DEPTH_24;
  assign pix_in.ready = load_ok;

  assign pal_wr.en    = acc && pix_in.command == CMD_PALETTE;
  assign pal_wr.index = pix_in.palette_index;
  assign pal_wr.color = pix_in.palette_color;

  always_comb begin
    if (cfg.width == '0) begin
      w_eff = CW'(1);
    end else if (EW'(cfg.width) > EW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(cfg.width);
    end
    if (cfg.height == '0) begin
      h_eff = 13'd1;
    end else if (cfg.height > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end else begin
      h_eff = cfg.height;
    end
  end

  // row length in bytes, padded to 32 bits
  assign wr = RCW'(w_eff);
  always_comb begin
    case (cfg.depth_code)
      DEPTH_1: begin
        rb_wide = ((wr + RCW'(31)) >> 5) << 2;
        per_byte = 4'd8;
      end
      DEPTH_2: begin
        rb_wide = ((wr + RCW'(15)) >> 4) << 2;
        per_byte = 4'd4;
      end
      DEPTH_4: begin
        rb_wide = ((wr + RCW'(7)) >> 3) << 2;
        per_byte = 4'd2;
      end
      DEPTH_8: begin
        rb_wide = ((wr + RCW'(3)) >> 2) << 2;
        per_byte = 4'd1;
      end
      default: begin
        rb_wide = ((wr + (wr << 1) + RCW'(3)) >> 2) << 2;
        per_byte = 4'd1;
      end
    endcase
  end
  assign row_bytes = RBW'(rb_wide);

  assign col_lt_w = col < w_eff;
  assign avail    = w_eff - col;
  assign last     = avail <= CW'(per_byte);
  assign n        = last ? avail[3:0] : per_byte;
  assign row_last = ({1'b0, row} + 13'd1) >= h_eff;
  assign rbc_inc  = rbc + RBW'(1);

  always_comb begin
    col_next    = col;
    rbc_next    = rbc;
    row_next    = row;
    hold_b_next = hold_b;
    hold_g_next = hold_g;
    phase_next  = phase;
    u_load      = 1'b0;
    ld_count    = n;
    ld_direct   = 1'b0;
    ld_rgb      = {pix_in.data_byte, hold_g, hold_b};
    ld_eor      = last;
    ld_eoi      = last && row_last;
    if (pix_acc) begin
      if (col_lt_w) begin
        if (cfg.depth_code == DEPTH_24) begin
          case (phase)
            2'd0: begin
              hold_b_next = pix_in.data_byte;
              phase_next  = 2'd1;
            end
            2'd1: begin
              hold_g_next = pix_in.data_byte;
              phase_next  = 2'd2;
            end
            default: begin
              u_load      = 1'b1;
              ld_direct   = 1'b1;
              col_next    = col + CW'(1);
              phase_next  = 2'd0;
              hold_b_next = '0;
              hold_g_next = '0;
            end
          endcase
        end else begin
          u_load   = 1'b1;
          col_next = col + CW'(n);
        end
      end
      rbc_next = rbc_inc;
      if (rbc_inc >= row_bytes) begin
        rbc_next    = '0;
        col_next    = '0;
        phase_next  = 2'd0;
        hold_b_next = '0;
        hold_g_next = '0;
        row_next    = row_last ? '0 : row + 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      rbc     <= '0;
      row     <= '0;
      hold_b  <= '0;
      hold_g  <= '0;
      phase   <= 2'd0;
      u_valid <= 1'b0;
    end else begin
      col    <= col_next;
      rbc    <= rbc_next;
      row    <= row_next;
      hold_b <= hold_b_next;
      hold_g <= hold_g_next;
      phase  <= phase_next;
      if (u_load) begin
        u_valid <= 1'b1;
      end else if (issue && u_count == 4'd1) begin
        u_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (u_load) begin
      u_count  <= ld_count;
      u_byte   <= pix_in.data_byte;
      u_code   <= cfg.depth_code[1:0];
      u_eor    <= ld_eor;
      u_eoi    <= ld_eoi;
      u_direct <= ld_direct;
      u_rgb    <= ld_rgb;
    end else if (issue) begin
      u_count <= u_count - 4'd1;
      u_byte  <= u_byte << (4'd1 << u_code);
    end
  end

  // indices come out MSB-first
  always_comb begin
    case (u_code)
      2'd0:    u_index = {7'd0, u_byte[7]};
      2'd1:    u_index = {6'd0, u_byte[7:6]};
      2'd2:    u_index = {4'd0, u_byte[7:4]};
      default: u_index = u_byte;
    endcase
  end

  assign iss_valid  = u_valid;
  assign iss.direct = u_direct;
  assign iss.index  = u_index;
  assign iss.rgb    = u_rgb;
  assign iss.eor    = u_eor && u_count == 4'd1;
  assign iss.eoi    = u_eoi && u_count == 4'd1;

  `ASSERT_PROP(a_count_live, clk, rst, u_valid |-> u_count != 4'd0, "empty unpacker slot")
  `ASSERT_PROP(a_direct_single, clk, rst, u_valid && u_direct |-> u_count == 4'd1, "24-bit multi")
  `ASSERT_NEVER(a_phase_range, clk, rst, phase == 2'd3, "bad byte phase")
  `ASSERT_NEVER(a_col_range, clk, rst, col > CW'(MAX_WIDTH), "column overrun")

endmodule

>>> hdl/bpup_lookup.sv
// Palette RAM, lookup stage and output register.
// Depends on bpup_pkg, bpup_out_if, bpup_ram, assert_macros.svh.
`include "assert_macros.svh"
module bpup_lookup #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bpup_pkg::bpup_pal_wr_t pal_wr,
  input  logic                   iss_valid,
  input  bpup_pkg::bpup_pix_t    iss,
  output logic                   iss_ready,
  bpup_out_if.source             pix_out
);
  import bpup_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic        r_valid, r_direct, r_zero, r_eor, r_eoi;
  logic [23:0] r_rgb;
  logic        o_valid, o_eor, o_eoi;
  logic [31:0] o_color, rdata;
  logic        out_free, re, we;

  assign out_free  = !o_valid || pix_out.ready;
  assign iss_ready = !r_valid || out_free;
  assign re        = iss_valid && iss_ready && !iss.direct;
  assign we        = pal_wr.en && {1'b0, pal_wr.index} < 9'(PALETTE_DEPTH);

  bpup_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (we),
    .waddr (pal_wr.index[AW-1:0]),
    .wdata (pal_wr.color),
    .re    (re),
    .raddr (iss.index[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (iss_ready) begin
        r_valid <= iss_valid;
      end
      if (out_free) begin
        o_valid <= r_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (iss_valid && iss_ready) begin
      r_direct <= iss.direct;
      r_zero   <= {1'b0, iss.index} >= 9'(PALETTE_DEPTH);
      r_rgb    <= iss.rgb;
      r_eor    <= iss.eor;
      r_eoi    <= iss.eoi;
    end
    if (r_valid && out_free) begin
      if (r_direct) begin
        o_color <= {8'd0, r_rgb};
      end else if (r_zero) begin
        o_color <= '0;
      end else begin
        o_color <= rdata;
      end
      o_eor <= r_eor;
      o_eoi <= r_eoi;
    end
  end

  assign pix_out.valid        = o_valid;
  assign pix_out.alpha_byte   = o_color[31:24];
  assign pix_out.red          = o_color[23:16];
  assign pix_out.green        = o_color[15:8];
  assign pix_out.blue         = o_color[7:0];
  assign pix_out.end_of_row   = o_eor;
  assign pix_out.end_of_image = o_eoi;

  `ASSERT_PROP(a_r_hold, clk, rst, r_valid && !out_free |=> r_valid, "lookup lost")
  `ASSERT_PROP(a_r_moves, clk, rst, r_valid && out_free |=> o_valid, "lookup not forwarded")
  `ASSERT_PROP(a_eoi_eor, clk, rst, o_valid && o_eoi |-> o_eor, "image end off row end")

endmodule

>>> hdl/bitmap_pixel_unpack_palette.sv
// Bitmap pixel-data unpacker with a palette lookup.
// Depends on bpup_pkg, bpup_in_if, bpup_out_if, bpup_seq, bpup_lookup.
//
// A palette write goes straight to the palette RAM. A pixel byte yields as many pixels
// as it holds in the row (one at 8 bpp, up to eight at 1 bpp); padding and partial
// 24-bit bytes yield none. The next byte is taken as the last pixel of a byte issues. The
// single palette read port sets the rate, one pixel per cycle barring output stalls;
// pixels pass the unpacker slot, lookup and output registers. Palette entries read
// before they are written return undefined data; there is no clearing pass.
module bitmap_pixel_unpack_palette #(
  parameter int MAX_WIDTH     = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             write_enable,
  input  logic [bpup_pkg::REG_IDX_W-1:0]   reg_index,
  input  logic [bpup_pkg::CFG_DATA_W-1:0]  write_data,
  bpup_in_if.sink                          pix_in,
  bpup_out_if.source                       pix_out
);
  import bpup_pkg::*;

  bpup_cfg_t    cfg;
  bpup_pal_wr_t pal_wr;
  bpup_pix_t    iss;
  logic         iss_valid, iss_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_code <= DEPTH_8;
      cfg.width      <= 13'd1;
      cfg.height     <= 13'd1;
    end else if (write_enable) begin
      case (reg_index)
        REG_DEPTH:  cfg.depth_code <= write_data[2:0];
        REG_WIDTH:  cfg.width      <= write_data;
        REG_HEIGHT: cfg.height     <= write_data;
        default: ;
      endcase
    end
  end

  bpup_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix_in    (pix_in),
    .pal_wr    (pal_wr),
    .iss_valid (iss_valid),
    .iss       (iss),
    .iss_ready (iss_ready)
  );

  bpup_lookup #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_lookup (
    .clk       (clk),
    .rst       (rst),
    .pal_wr    (pal_wr),
    .iss_valid (iss_valid),
    .iss       (iss),
    .iss_ready (iss_ready),
    .pix_out   (pix_out)
  );

endmodule

>>> dv/tb_bitmap_pixel_unpack_palette.sv
`timescale 1ns / 1ps
// Testbench for bitmap_pixel_unpack_palette: directed table plus random requests.
// Depends on bpup_pkg, bpup_in_if, bpup_out_if and the RTL top level.
module tb_bitmap_pixel_unpack_palette;
  import bpup_pkg::*;

  localparam int MAX_WIDTH = 4096;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_byte;
    logic       end_of_row;
    logic       end_of_image;
  } pixel_t;

  typedef struct packed {
    logic        command;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [31:0] palette_color;
  } unpack_req_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PAL, ROW_PIX} dir_kind_t;

  typedef struct packed {
    dir_kind_t              kind;
    logic [REG_IDX_W-1:0]   reg_sel;
    logic [31:0]            value;
    logic [7:0]             index;
    logic                   typed;
    pixel_t                 pix;
  } dir_row_t;

  localparam pixel_t NO_PIX = '0;
  localparam int N_DIRECTED = 39;

  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_PAL, REG_DEPTH, 32'h0000_0000, 8'h00, 1'b0, NO_PIX},
    '{ROW_PAL, REG_DEPTH, 32'hFFFF_FFFF, 8'hFF, 1'b0, NO_PIX},
    '{ROW_PAL, REG_DEPTH, 32'h8012_3456, 8'h01, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_00FF, 8'h00, 1'b1,
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1}},
    '{ROW_PIX, REG_DEPTH, 32'h0000_0000, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_00FF, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_005A, 8'h00, 1'b0, NO_PIX},
    '{ROW_CFG, REG_WIDTH, 32'h0000_0000, 8'h00, 1'b0, NO_PIX},
    '{ROW_CFG, REG_HEIGHT, 32'h0000_0000, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_0001, 8'h00, 1'b1,
      '{8'h12, 8'h34, 8'h56, 8'h80, 1'b1, 1'b1}},
    '{ROW_PIX, REG_DEPTH, 32'h0000_00A5, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_003C, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_00C3, 8'h00, 1'b0, NO_PIX},
    '{ROW_CFG, REG_DEPTH, 32'(DEPTH_24), 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_0011, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_0022, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_0033, 8'h00, 1'b1,
      '{8'h33, 8'h22, 8'h11, 8'h00, 1'b1, 1'b1}},
    '{ROW_PIX, REG_DEPTH, 32'h0000_0099, 8'h00, 1'b0, NO_PIX},
    '{ROW_CFG, REG_DEPTH, 32'(DEPTH_1), 8'h00, 1'b0, NO_PIX},
    '{ROW_CFG, REG_WIDTH, 32'd27, 8'h00, 1'b0, NO_PIX},
    '{ROW_CFG, REG_HEIGHT, 32'd2, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_0080, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_007F, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_00AA, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_00E0, 8'h00, 1'b0, NO_PIX},
    '{ROW_CFG, REG_DEPTH, 32'(DEPTH_2), 8'h00, 1'b0, NO_PIX},
    '{ROW_CFG, REG_WIDTH, 32'd13, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_001B, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_00E4, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_00FF, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_0040, 8'h00, 1'b0, NO_PIX},
    '{ROW_CFG, REG_DEPTH, 32'(DEPTH_4), 8'h00, 1'b0, NO_PIX},
    '{ROW_CFG, REG_WIDTH, 32'd7, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_0001, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_0023, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_00EF, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_00F0, 8'h00, 1'b0, NO_PIX},
    '{ROW_CFG, REG_DEPTH, 32'd7, 8'h00, 1'b0, NO_PIX},
    '{ROW_PIX, REG_DEPTH, 32'h0000_0077, 8'h00, 1'b0, NO_PIX}
  };

  logic                  clk;
  logic                  rst;
  logic                  write_enable;
  logic [REG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] write_data;

  bpup_in_if  pix_in_bus();
  bpup_out_if pix_out_bus();

  bitmap_pixel_unpack_palette #(.MAX_WIDTH(MAX_WIDTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .pix_in       (pix_in_bus),
    .pix_out      (pix_out_bus)
  );

  // predictor state
  logic [31:0] color_table [256];
  logic [2:0]  cfg_depth;
  logic [12:0] cfg_width;
  logic [12:0] cfg_height;
  int unsigned col_count;
  int unsigned row_bytes_seen;
  int unsigned row_num;
  logic [15:0] bgr_hold;
  int unsigned rgb_phase;

  pixel_t pending_pixels[$];

  int mismatch_count;
  int pixels_checked;
  int request_count;
  int setting_count;
  int send_idle_pct;
  int stall_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("bitmap_pixel_unpack_palette regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("MISMATCH pixel %0d %s: got %0h expected %0h", pixels_checked, what, got,
             want);
  endtask

  task automatic predict_pixels(input unpack_req_t r);
    int unsigned bpp, w, h, row_len, slots, s;
    logic [31:0] word;
    logic [7:0]  idx;
    pixel_t      px;
    if (r.command == CMD_PALETTE) begin
      color_table[r.palette_index] = r.palette_color;
      return;
    end
    if (cfg_depth > DEPTH_24) return;
    case (cfg_depth)
      DEPTH_1: bpp = 1;
      DEPTH_2: bpp = 2;
      DEPTH_4: bpp = 4;
      DEPTH_8: bpp = 8;
      default: bpp = 24;
    endcase
    w = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
    h = (cfg_height == 0) ? 1 : (cfg_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : cfg_height;
    row_len = ((w * bpp + 31) / 32) * 4;
    slots = (bpp == 24) ? 1 : 8 / bpp;
    for (s = 0; s < slots && col_count < w; s++) begin
      if (bpp == 24 && rgb_phase != 2) begin
        if (rgb_phase == 0) bgr_hold = {8'h00, r.data_byte};
        else bgr_hold = {r.data_byte, bgr_hold[7:0]};
        rgb_phase++;
      end else begin
        if (bpp == 24) begin
          word = {8'h00, r.data_byte, bgr_hold};
          bgr_hold = '0;
          rgb_phase = 0;
        end else begin
          idx = 8'(r.data_byte >> (8 - bpp * (s + 1))) & 8'((1 << bpp) - 1);
          word = color_table[idx];
        end
        col_count++;
        px.red = word[23:16];
        px.green = word[15:8];
        px.blue = word[7:0];
        px.alpha_byte = word[31:24];
        px.end_of_row = (col_count >= w);
        px.end_of_image = px.end_of_row && (row_num + 1 >= h);
        pending_pixels.push_back(px);
      end
    end
    row_bytes_seen++;
    if (row_bytes_seen >= row_len) begin
      row_bytes_seen = 0;
      col_count = 0;
      rgb_phase = 0;
      bgr_hold = '0;
      row_num++;
      if (row_num >= h) row_num = 0;
    end
  endtask

  task automatic send_item(input unpack_req_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix_in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    pix_in_bus.valid <= 1'b1;
    pix_in_bus.command <= r.command;
    pix_in_bus.data_byte <= r.data_byte;
    pix_in_bus.palette_index <= r.palette_index;
    pix_in_bus.palette_color <= r.palette_color;
    do @(posedge clk); while (!pix_in_bus.ready);
    request_count++;
    predict_pixels(r);
  endtask

  // drop valid, wait for every pending pixel, then let the pipeline empty
  task automatic settle(input int extra);
    @(negedge clk);
    pix_in_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_register(input logic [REG_IDX_W-1:0] sel,
                                input logic [CFG_DATA_W-1:0] value);
    settle(8);
    @(negedge clk);
    write_enable <= 1'b1;
    reg_index <= sel;
    write_data <= value;
    case (sel)
      REG_DEPTH:  cfg_depth = value[2:0];
      REG_WIDTH:  cfg_width = value[12:0];
      REG_HEIGHT: cfg_height = value[12:0];
      default: ;
    endcase
    setting_count++;
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  always @(negedge clk) begin
    pix_out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (!rst && pix_out_bus.valid && pix_out_bus.ready) begin
      got = '{pix_out_bus.red, pix_out_bus.green, pix_out_bus.blue,
              pix_out_bus.alpha_byte, pix_out_bus.end_of_row, pix_out_bus.end_of_image};
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel with none pending", 32'(got), 32'h0);
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red)
          report_mismatch("red", 32'(got.red), 32'(want.red));
        if (got.green !== want.green)
          report_mismatch("green", 32'(got.green), 32'(want.green));
        if (got.blue !== want.blue)
          report_mismatch("blue", 32'(got.blue), 32'(want.blue));
        if (got.alpha_byte !== want.alpha_byte)
          report_mismatch("alpha_byte", 32'(got.alpha_byte), 32'(want.alpha_byte));
        if (got.end_of_row !== want.end_of_row)
          report_mismatch("end_of_row", 32'(got.end_of_row), 32'(want.end_of_row));
        if (got.end_of_image !== want.end_of_image)
          report_mismatch("end_of_image", 32'(got.end_of_image), 32'(want.end_of_image));
      end
      pixels_checked++;
    end
  end

  initial begin
    unpack_req_t req;
    int row, phase, counted;
    logic [CFG_DATA_W-1:0] width_val, height_val, depth_val;

    rst = 1'b1;
    write_enable = 1'b0;
    reg_index = '0;
    write_data = '0;
    pix_in_bus.valid = 1'b0;
    pix_in_bus.command = CMD_PALETTE;
    pix_in_bus.data_byte = '0;
    pix_in_bus.palette_index = '0;
    pix_in_bus.palette_color = '0;
    pix_out_bus.ready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    mismatch_count = 0;
    pixels_checked = 0;
    request_count = 0;
    setting_count = 0;
    cfg_depth = DEPTH_8;
    cfg_width = 13'd1;
    cfg_height = 13'd1;
    col_count = 0;
    row_bytes_seen = 0;
    row_num = 0;
    bgr_hold = '0;
    rgb_phase = 0;
    foreach (color_table[i]) color_table[i] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill the low 16 slots; random 8 bpp pixel bytes below stay inside them
    for (row = 0; row < 16; row++) begin
      req.command = CMD_PALETTE;
      req.data_byte = 8'($urandom);
      req.palette_index = 8'(row);
      req.palette_color = $urandom;
      send_item(req);
    end

    for (row = 0; row < N_DIRECTED; row++) begin
      if (DIRECTED[row].kind == ROW_CFG) begin
        write_register(DIRECTED[row].reg_sel, DIRECTED[row].value[CFG_DATA_W-1:0]);
      end else begin
        req.command = (DIRECTED[row].kind == ROW_PAL) ? CMD_PALETTE : CMD_PIXEL;
        req.data_byte = DIRECTED[row].value[7:0];
        req.palette_index = DIRECTED[row].index;
        req.palette_color = DIRECTED[row].value;
        send_item(req);
        if (DIRECTED[row].typed) begin
          void'(pending_pixels.pop_back());
          pending_pixels.push_back(DIRECTED[row].pix);
        end
      end
    end

    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 69; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 69; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      depth_val = (phase < 6) ? CFG_DATA_W'(phase) : CFG_DATA_W'($urandom_range(0, 7));
      case (phase)
        1: width_val = 13'h1FFF;
        2: width_val = 13'd4096;
        3: width_val = 13'd0;
        default: width_val = 13'($urandom_range(1, 12));
      endcase
      case (phase)
        4: height_val = 13'h1FFF;
        5: height_val = 13'd4096;
        6: height_val = 13'd0;
        default: height_val = 13'($urandom_range(1, 3));
      endcase
      write_register(REG_DEPTH, depth_val);
      write_register(REG_WIDTH, width_val);
      write_register(REG_HEIGHT, height_val);
      for (counted = 0; counted < 14; counted++) begin
        req.command = ($urandom_range(0, 99) < 12) ? CMD_PALETTE : CMD_PIXEL;
        req.data_byte = (cfg_depth == DEPTH_8) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        req.palette_index = 8'($urandom);
        req.palette_color = $urandom;
        send_item(req);
        if (phase == 0 && counted == 6) settle(0);
      end
    end

    settle(16);
    $display("covered %0d requests and %0d pixels over %0d register writes",
             request_count, pixels_checked, setting_count);
    $display("depths 1/2/4/8/24 and unused codes, width and height extremes, mid-row changes");
    if (mismatch_count == 0) begin
      $display("bitmap_pixel_unpack_palette regression: pass");
    end else begin
      $display("bitmap_pixel_unpack_palette regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/bpup_pkg.sv
hdl/bpup_in_if.sv
hdl/bpup_out_if.sv
hdl/bpup_ram.sv
hdl/bpup_seq.sv
hdl/bpup_lookup.sv
hdl/bitmap_pixel_unpack_palette.sv
dv/tb_bitmap_pixel_unpack_palette.sv
